### rtl/gaht_pkg.sv
// Shared types and constants for the graph adjacency two-hop table.
package gaht_pkg;

    // Fixed width of a node identifier and the largest number of adjacency rows.
    localparam int ID_W      = 6;
    localparam int ROW_LIMIT = 64;

    // Operation codes carried by an input word.
    typedef enum logic [1:0] {
        OP_ADD_NODE = 2'd0,
        OP_ADD_EDGE = 2'd1,
        OP_CHECK    = 2'd2,
        OP_UNUSED   = 2'd3
    } t_op;

    // Input word: one operation on one or two node identifiers.
    typedef struct packed {
        t_op             operation;
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] second_id;
    } t_in_word;

    // Output word: connectivity answer and node status.
    typedef struct packed {
        logic connected;
        logic status;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic first;   // take the input word and perform the first row access
        logic second;  // perform the second row access
        logic finish;  // load the result of a check into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // the output register can take a word this cycle
        logic item_check;  // the word in progress is a check
    } t_stat;

endpackage

### rtl/gaht_ctrl.sv
// Controller state machine that sequences the two row accesses of each word.
module gaht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gaht_pkg::t_stat i_stat,
    output gaht_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SECOND = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;

    // Next state and command decode.
    always_comb begin
        n_state      = r_state;
        n_pend       = r_pend;
        o_in_ready   = 1'b0;
        o_cmd.first  = 1'b0;
        o_cmd.second = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // A pending check result must find the output register free.
                o_in_ready   = !r_pend || i_stat.out_free;
                o_cmd.finish = r_pend && i_stat.out_free;
                o_cmd.first  = i_in_valid && o_in_ready;
                if (o_cmd.finish) begin
                    n_pend = 1'b0;
                end
                if (o_cmd.first) begin
                    n_state = ST_SECOND;
                end
            end
            ST_SECOND: begin
                if (i_stat.item_check) begin
                    // The check result is formed in a later idle cycle, once the output register is free.
                    o_cmd.second = 1'b1;
                    n_pend       = 1'b1;
                    n_state      = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.second = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_pend  = 1'b0;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule

### rtl/gaht_dp.sv
// Datapath with the node bitmap, the adjacency row memory and the output register.
module gaht_dp #(
    parameter int ROWS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gaht_pkg::t_cmd      i_cmd,
    input  gaht_pkg::t_in_word  i_in_word,
    output gaht_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    output gaht_pkg::t_out_word o_out_word,
    input  logic                i_out_ready
);

    localparam int              AW     = $clog2(ROWS);
    localparam int              LW     = gaht_pkg::ID_W + 1;
    localparam logic [LW-1:0]   ROWS_L = LW'(ROWS);
    localparam logic [ROWS-1:0] ONE    = ROWS'(1);

    // Node bitmap, row valid flags and the row memory.
    logic [ROWS-1:0] r_present;
    logic [ROWS-1:0] r_row_valid;
    logic [ROWS-1:0] r_mem [ROWS];

    // Word in progress.
    gaht_pkg::t_op   r_op;
    logic [AW-1:0]   r_a;
    logic [AW-1:0]   r_b;
    logic            r_bad;

    // Read data, its valid flag and the captured first row.
    logic [ROWS-1:0] r_rd;
    logic            r_rd_ok;
    logic [ROWS-1:0] r_row_a;

    // Output register.
    logic                r_out_valid;
    gaht_pkg::t_out_word r_out;

    logic [AW-1:0]   w_a_idx, w_b_idx;
    logic            w_a_in, w_b_in, w_a_pres, w_b_pres, w_both, w_bad;
    logic [AW-1:0]   w_addr;
    logic            w_we, w_re;
    logic [ROWS-1:0] w_wdata, w_wmask;
    logic [ROWS-1:0] w_rd_eff;
    logic            w_load;
    gaht_pkg::t_out_word w_res;

    // Presence of the identifiers in the incoming word.
    assign w_a_idx  = i_in_word.first_id[AW-1:0];
    assign w_b_idx  = i_in_word.second_id[AW-1:0];
    assign w_a_in   = {1'b0, i_in_word.first_id} < ROWS_L;
    assign w_b_in   = {1'b0, i_in_word.second_id} < ROWS_L;
    assign w_a_pres = w_a_in && r_present[w_a_idx];
    assign w_b_pres = w_b_in && r_present[w_b_idx];
    assign w_both   = w_a_pres && w_b_pres;

    // Status of the word: absent node for edges and checks, out of table for adds.
    always_comb begin
        unique case (i_in_word.operation)
            gaht_pkg::OP_ADD_NODE: w_bad = !w_a_in;
            gaht_pkg::OP_ADD_EDGE: w_bad = !w_both;
            gaht_pkg::OP_CHECK:    w_bad = !w_both;
            default:               w_bad = 1'b0;
        endcase
    end

    // Memory port: row of the first node on accept, row of the second one after.
    always_comb begin
        w_addr  = '0;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_wdata = '0;
        if (i_cmd.first) begin
            w_addr  = w_a_idx;
            w_wdata = ONE << w_b_idx;
            w_we    = (i_in_word.operation == gaht_pkg::OP_ADD_EDGE) && w_both;
            w_re    = (i_in_word.operation == gaht_pkg::OP_CHECK) && w_both;
        end else if (i_cmd.second) begin
            w_addr  = r_b;
            w_wdata = ONE << r_a;
            w_we    = (r_op == gaht_pkg::OP_ADD_EDGE) && !r_bad;
            w_re    = (r_op == gaht_pkg::OP_CHECK) && !r_bad;
        end
        // A row never written is rewritten whole so that its stale bits vanish.
        w_wmask = r_row_valid[w_addr] ? w_wdata : '1;
    end

    // Row memory with bit write enables and a registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            for (int i = 0; i < ROWS; i++) begin
                if (w_wmask[i]) begin
                    r_mem[w_addr][i] <= w_wdata[i];
                end
            end
        end
        if (w_re) begin
            r_rd    <= r_mem[w_addr];
            r_rd_ok <= r_row_valid[w_addr];
        end
    end

    assign w_rd_eff = r_rd_ok ? r_rd : '0;

    // Node bitmap and row valid flags, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_row_valid <= '0;
        end else begin
            if (i_cmd.first && (i_in_word.operation == gaht_pkg::OP_ADD_NODE) && w_a_in) begin
                r_present[w_a_idx] <= 1'b1;
            end
            if (w_we) begin
                r_row_valid[w_addr] <= 1'b1;
            end
        end
    end

    // Capture of the word in progress and of the first row of a check.
    always_ff @(posedge i_clk) begin
        if (i_cmd.first) begin
            r_op  <= i_in_word.operation;
            r_a   <= w_a_idx;
            r_b   <= w_b_idx;
            r_bad <= w_bad;
        end
        if (i_cmd.second) begin
            r_row_a <= w_rd_eff;
        end
    end

    // Result: status for every word; a check also tests the first row for the second node and against the second row.
    always_comb begin
        w_res.status    = r_bad;
        w_res.connected = 1'b0;
        if (i_cmd.finish) begin
            w_res.connected = !r_bad && (r_row_a[r_b] || (|(r_row_a & w_rd_eff)));
        end
    end

    assign w_load = i_cmd.finish || (i_cmd.second && (r_op != gaht_pkg::OP_CHECK));

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.item_check = (r_op == gaht_pkg::OP_CHECK);

endmodule

### rtl/graph_adjacency_two_hop_table.sv
// Top level of the graph adjacency two-hop table.
// Add node, add edge and unused codes load their output word at their second row access,
// a check loads it at the finish step in a later idle state, once the output register is free.
// The two accesses to the single-port row memory keep a word from being taken during a second access.
// Reset clears the node bitmap and the row valid flags; no clearing pass follows.
module graph_adjacency_two_hop_table #(
    parameter int MAX_NODES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gaht_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gaht_pkg::t_out_word o_out_word
);

    localparam int ROWS = (MAX_NODES < gaht_pkg::ROW_LIMIT) ? MAX_NODES : gaht_pkg::ROW_LIMIT;

    gaht_pkg::t_cmd  w_cmd;
    gaht_pkg::t_stat w_stat;

    // Sequencer.
    gaht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Storage and result logic.
    gaht_dp #(
        .ROWS (ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_word   (i_in_word),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_ready (i_out_ready)
    );

    // The two row accesses never fall in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.first && w_cmd.second))
        else $error("first and second row access at once");

    // The cycle after a word is taken is reserved for its second access.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.first |=> !o_in_ready)
        else $error("word taken during a second access");

    // A check result is only loaded into a free output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> w_stat.out_free)
        else $error("check result loaded into a full output register");

    // Other results are only loaded into a free output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.second && !w_stat.item_check) |-> w_stat.out_free)
        else $error("result loaded into a full output register");

endmodule
